FILE: rtl/ipbt_pkg.sv
// Shared types, codes and the match function of the IPv4 range ban table.
// Used by every module under rtl; depends on nothing else.
package ipbt_pkg;

   // Operation codes carried in the mode field of a request word.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // The first dotted octet is always compared, whatever the care mask says.
   localparam int unsigned OCTET_SHIFT = 24;
   localparam logic [31:0] OCTET_BITS  = 32'h0000_00FF << OCTET_SHIFT;

   typedef struct packed {
      logic        mode;
      logic [31:0] addr_first;
      logic [31:0] addr_last;
   } req_word_type;

   typedef struct packed {
      logic banned;
      logic table_full;
   } rsp_word_type;

   // One stored table entry: base address and care mask.
   typedef struct packed {
      logic [31:0] base;
      logic [31:0] care_mask;
   } entry_type;

   // Forms the entry stored for an insert of the range first to last.
   function automatic entry_type make_entry(input logic [31:0] first,
                                            input logic [31:0] last);
      entry_type e;
      e.base      = first;
      e.care_mask = ~(first ^ last);
      return e;
   endfunction

   // True when addr falls in the range that entry e describes.
   function automatic logic entry_match(input entry_type e, input logic [31:0] addr);
      logic [31:0] care;
      care = e.care_mask | OCTET_BITS;
      return ((e.base ^ addr) & care) == 32'h0000_0000;
   endfunction

endpackage

FILE: rtl/ipbt_table.sv
// Entry store of the IPv4 range ban table: one write port, one read port,
// read data registered. Depends on ipbt_pkg for the entry type.
module ipbt_table #(
   parameter int unsigned ENTRIES = 256,
   parameter int unsigned IDX_W   = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  ipbt_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output ipbt_pkg::entry_type rd_data
);

   ipbt_pkg::entry_type mem [ENTRIES];
   ipbt_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; read data registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ipbt_ctrl.sv
// Sequencer of the IPv4 range ban table: takes words, keeps the fill count,
// scans the entry store on lookups and holds the response register.
// Depends on ipbt_pkg.
module ipbt_ctrl #(
   parameter int unsigned ENTRIES = 256,
   parameter int unsigned IDX_W   = 8,
   parameter int unsigned CNT_W   = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ipbt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ipbt_pkg::rsp_word_type rsp_word,
   output logic                   mem_wr_en,
   output logic [IDX_W-1:0]       mem_wr_addr,
   output logic                   mem_rd_en,
   output logic [IDX_W-1:0]       mem_rd_addr,
   input  ipbt_pkg::entry_type    mem_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic [31:0]            addr_ff, addr_in;
   ipbt_pkg::rsp_word_type res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ipbt_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   table_is_full;
   logic                   hit_now;

   assign table_is_full = (count_ff == CNT_W'(ENTRIES));
   // A read issued last cycle returns its entry now; compare it.
   assign hit_now       = pend_ff && ipbt_pkg::entry_match(mem_rd_data, addr_ff);

   assign mem_wr_addr = count_ff[IDX_W-1:0];
   assign mem_rd_addr = scan_ff[IDX_W-1:0];

   // Next state, table accesses and response handling.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;

      // The waiting word leaves when the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_word.mode == ipbt_pkg::MODE_INSERT) begin
                  res_in.banned = 1'b0;
                  if (table_is_full) begin
                     res_in.table_full = 1'b1;
                  end else begin
                     res_in.table_full = 1'b0;
                     mem_wr_en         = 1'b1;
                     count_in          = count_ff + CNT_W'(1);
                  end
                  state_in = ST_FINISH;
               end else begin
                  addr_in  = req_word.addr_first;
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Stop on the first hit or once every written entry was compared.
            if (hit_now || (scan_ff == count_ff)) begin
               res_in.banned     = hit_now;
               res_in.table_full = 1'b0;
               state_in          = ST_FINISH;
            end else begin
               mem_rd_en = 1'b1;
               scan_in   = scan_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      addr_ff     <= addr_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/ip_range_ban_table_unit.sv
// Top level of the IPv4 range ban table: sequencer plus entry store.
// Depends on ipbt_pkg, ipbt_table and ipbt_ctrl.
//
// Usage:
//   A request word (req_valid / req_stall / req_word) either inserts a range,
//   kept as base address and care mask, or looks up one address. Every word
//   gives exactly one response word (rsp_valid / rsp_stall / rsp_word):
//   banned for lookups, table_full for an insert into a full table, which is
//   then dropped.
//   An insert writes its entry to the store when it is taken and then passes
//   to the response register through the finish state. A lookup reads the
//   store one entry per cycle through its single read port, comparing each
//   entry as it returns; it stops early on the first matching entry.
//   Only one word is at work at a time; req_stall is high from the cycle after
//   a word is taken until its result has moved into the response register.
//   A response held by rsp_stall stays in its register while the next word is
//   taken and worked on; that word's result waits until the register frees.
//   Reset empties the table by clearing the fill count; no clearing pass is
//   run, and the block takes words in the first cycle after reset.
module ip_range_ban_table_unit #(
   parameter int unsigned ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ipbt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ipbt_pkg::rsp_word_type rsp_word
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;
   ipbt_pkg::entry_type mem_rd_data;
   ipbt_pkg::entry_type mem_wr_data;

   // Entry formed from the insert range.
   assign mem_wr_data = ipbt_pkg::make_entry(req_word.addr_first, req_word.addr_last);

   ipbt_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ipbt_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
